// ===== hw/rtl/ccr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants for the circle/box collision pipeline.
// ----------------------------------------------------------------------------
package ccr_pkg;

	// Box side chosen when the centre lies inside the box
	typedef enum logic [1:0] {
		SIDE_LEFT,
		SIDE_RIGHT,
		SIDE_TOP,
		SIDE_BOTTOM
	} side_t;

	localparam int SQ_STAGES  = 16;  // one root bit per stage
	localparam int DIV_STAGES = 15;  // one quotient bit per stage

	localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

	// Per-beat context carried alongside the square root and divider
	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [11:0]        r;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic               hit;
		logic               outside;
		logic               sx;
		logic               sy;
		logic [11:0]        ax;
		logic [11:0]        ay;
		logic [14:0]        best;
		side_t              side;
	} ctx_t;

endpackage

// ===== hw/rtl/circle_box_collision_resolve_top.sv =====
// ----------------------------------------------------------------------------
// circle_box_collision_resolve_top
// Circle against axis-aligned box: contact test, normal, penetration,
// push-out and velocity reflection, fully pipelined.
//
//   Channel   Dir  Signals                  Content
//   s_axis    in   s_tvalid/tready/tdata    circle, velocity and box
//   m_axis    out  m_tvalid/tready/tdata    normal, depth, new position and
//                  m_tuser                  velocity; tuser carries hit
//
// One beat enters per cycle unless a stall on m_tready reaches s_tready.
// Stages: 3 front, 16 root, 15 divider, 5 back (last is the output register).
// Every stage holds a valid bit and loads when empty or when the stage after
// it loads, so a stall on m_tready fills bubbles before it stops s_tready.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module circle_box_collision_resolve_top import ccr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// center_x[15:0], center_y[31:16], circle_radius[43:32], vel_x[59:44],
	// vel_y[75:60], box_left[91:76], box_top[107:92], box_width[122:108],
	// box_height[137:123], zero pad[143:138]
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// normal_x[15:0], normal_y[31:16], penetration[47:32], new_x[63:48],
	// new_y[79:64], new_vel_x[95:80], new_vel_y[111:96]
	output logic [111:0] m_tdata,
	// hit[0]
	output logic [0:0]   m_tuser
);

	// Front: clamp, squares, hit
	logic        f_valid, f_ready;
	ctx_t        f_ctx;
	logic [23:0] f_d2;

	ccr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.center_x      (s_tdata[15:0]),
		.center_y      (s_tdata[31:16]),
		.circle_radius (s_tdata[43:32]),
		.vel_x         (s_tdata[59:44]),
		.vel_y         (s_tdata[75:60]),
		.box_left      (s_tdata[91:76]),
		.box_top       (s_tdata[107:92]),
		.box_width     (s_tdata[122:108]),
		.box_height    (s_tdata[137:123]),
		.out_valid     (f_valid),
		.out_ready     (f_ready),
		.out_ctx       (f_ctx),
		.out_d2        (f_d2)
	);

	// Distance by square root
	logic        r_valid, r_ready;
	logic [15:0] r_root;
	ctx_t        r_ctx;

	ccr_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_d2     (f_d2),
		.in_ctx    (f_ctx),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.out_root  (r_root),
		.out_ctx   (r_ctx)
	);

	// Normal components by division
	logic        d_valid, d_ready;
	logic [14:0] d_qx, d_qy;
	logic [15:0] d_dist;
	ctx_t        d_ctx;

	ccr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid),
		.in_ready  (r_ready),
		.in_root   (r_root),
		.in_ctx    (r_ctx),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_qx    (d_qx),
		.out_qy    (d_qy),
		.out_dist  (d_dist),
		.out_ctx   (d_ctx)
	);

	// Push-out and reflection
	ccr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (d_valid),
		.in_ready    (d_ready),
		.in_qx       (d_qx),
		.in_qy       (d_qy),
		.in_dist     (d_dist),
		.in_ctx      (d_ctx),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.hit         (m_tuser[0]),
		.normal_x    (m_tdata[15:0]),
		.normal_y    (m_tdata[31:16]),
		.penetration (m_tdata[47:32]),
		.new_x       (m_tdata[63:48]),
		.new_y       (m_tdata[79:64]),
		.new_vel_x   (m_tdata[95:80]),
		.new_vel_y   (m_tdata[111:96])
	);

endmodule

// ===== hw/rtl/ccr_front.sv =====
// ----------------------------------------------------------------------------
// ccr_front
// Clamp the centre to the box, form squared offset and radius, pick the
// nearest side, decide hit. Three register stages.
// ----------------------------------------------------------------------------
module ccr_front import ccr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] center_x,
	input  logic signed [15:0] center_y,
	input  logic [11:0]        circle_radius,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] box_left,
	input  logic signed [15:0] box_top,
	input  logic [14:0]        box_width,
	input  logic [14:0]        box_height,
	output logic               out_valid,
	input  logic               out_ready,
	output ctx_t               out_ctx,
	output logic [23:0]        out_d2
);

	localparam int N = 3;

	logic [N-1:0] v_s;
	logic [N:0]   en;

	// Stage enables: a stage loads when empty or when the next one loads
	always_comb begin
		en[N] = out_ready;
		for (int k = N - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[N-1];

	// Stage 1: edges, clamp, offsets and side distances
	logic signed [16:0] cx17, cy17, left17, top17, right17, bottom17, cxc, cyc;
	logic signed [17:0] dx_c, dy_c;
	logic signed [16:0] dl_c, dr_c, dt_c, db_c;

	always_comb begin
		cx17     = {center_x[15], center_x};
		cy17     = {center_y[15], center_y};
		left17   = {box_left[15], box_left};
		top17    = {box_top[15], box_top};
		right17  = left17 + $signed({2'b00, box_width});
		bottom17 = top17 + $signed({2'b00, box_height});
		cxc = (cx17 < left17) ? left17 : ((cx17 > right17) ? right17 : cx17);
		cyc = (cy17 < top17) ? top17 : ((cy17 > bottom17) ? bottom17 : cy17);
		dx_c = {cx17[16], cx17} - {cxc[16], cxc};
		dy_c = {cy17[16], cy17} - {cyc[16], cyc};
		dl_c = cx17 - left17;
		dr_c = right17 - cx17;
		dt_c = cy17 - top17;
		db_c = bottom17 - cy17;
	end

	logic signed [17:0] dx_s1, dy_s1;
	logic [14:0]        dl_s1, dr_s1, dt_s1, db_s1;
	logic signed [15:0] cx_s1, cy_s1, vx_s1, vy_s1;
	logic [11:0]        r_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			dl_s1 <= dl_c[14:0];
			dr_s1 <= dr_c[14:0];
			dt_s1 <= dt_c[14:0];
			db_s1 <= db_c[14:0];
			cx_s1 <= center_x;
			cy_s1 <= center_y;
			vx_s1 <= vel_x;
			vy_s1 <= vel_y;
			r_s1  <= circle_radius;
		end
	end

	// Stage 2: squares, range check, nearest side
	logic signed [12:0] dx13, dy13, adx, ady;
	logic signed [25:0] sqx_c, sqy_c;
	logic [23:0]        r2_c;
	logic               small_c;
	logic [14:0]        best_c;
	side_t              side_c;

	always_comb begin
		dx13    = dx_s1[12:0];
		dy13    = dy_s1[12:0];
		adx     = dx13[12] ? -dx13 : dx13;
		ady     = dy13[12] ? -dy13 : dy13;
		sqx_c   = dx13 * dx13;
		sqy_c   = dy13 * dy13;
		r2_c    = r_s1 * r_s1;
		small_c = (dx_s1 > -18'sd4096) && (dx_s1 < 18'sd4096) &&
			(dy_s1 > -18'sd4096) && (dy_s1 < 18'sd4096);
		// ties keep the earlier side: left, right, top, bottom
		best_c = dl_s1;
		side_c = SIDE_LEFT;
		if (dr_s1 < best_c) begin
			best_c = dr_s1;
			side_c = SIDE_RIGHT;
		end
		if (dt_s1 < best_c) begin
			best_c = dt_s1;
			side_c = SIDE_TOP;
		end
		if (db_s1 < best_c) begin
			best_c = db_s1;
			side_c = SIDE_BOTTOM;
		end
	end

	logic [23:0] sqx_s2, sqy_s2, r2_s2;
	logic        small_s2;
	ctx_t        ctx_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sqx_s2         <= sqx_c[23:0];
			sqy_s2         <= sqy_c[23:0];
			r2_s2          <= r2_c;
			small_s2       <= small_c;
			ctx_s2.cx      <= cx_s1;
			ctx_s2.cy      <= cy_s1;
			ctx_s2.r       <= r_s1;
			ctx_s2.vx      <= vx_s1;
			ctx_s2.vy      <= vy_s1;
			ctx_s2.hit     <= 1'b0;
			ctx_s2.outside <= 1'b0;
			ctx_s2.sx      <= dx13[12];
			ctx_s2.sy      <= dy13[12];
			ctx_s2.ax      <= adx[11:0];
			ctx_s2.ay      <= ady[11:0];
			ctx_s2.best    <= best_c;
			ctx_s2.side    <= side_c;
		end
	end

	// Stage 3: squared distance against squared radius
	logic [24:0] d2_c;
	assign d2_c = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	ctx_t        ctx_c3;

	always_comb begin
		ctx_c3         = ctx_s2;
		ctx_c3.hit     = small_s2 && (d2_c <= {1'b0, r2_s2});
		ctx_c3.outside = (d2_c != '0);
	end

	ctx_t        ctx_s3;
	logic [23:0] d2_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ctx_s3 <= ctx_c3;
			d2_s3  <= d2_c[23:0];
		end
	end

	assign out_ctx = ctx_s3;
	assign out_d2  = d2_s3;

endmodule

// ===== hw/rtl/ccr_sqrt.sv =====
// ----------------------------------------------------------------------------
// ccr_sqrt
// Pipelined integer square root of d2 * 256, one root bit per stage.
// ----------------------------------------------------------------------------
module ccr_sqrt import ccr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] in_d2,
	input  ctx_t        in_ctx,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_root,
	output ctx_t        out_ctx
);

	localparam int N = SQ_STAGES;

	logic [N-1:0] v_s;
	logic [N:0]   en;

	always_comb begin
		en[N] = out_ready;
		for (int k = N - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[N-1];

	logic [31:0] n_s    [N];
	logic [17:0] rem_s  [N];
	logic [15:0] root_s [N];
	ctx_t        ctx_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [31:0] n_in;
		logic [17:0] rem_in;
		logic [15:0] root_in;
		ctx_t        ctx_in;
		logic [19:0] remsh, trial;

		if (k == 0) begin : g_first
			assign n_in    = {in_d2, 8'h00};
			assign rem_in  = '0;
			assign root_in = '0;
			assign ctx_in  = in_ctx;
		end else begin : g_next
			assign n_in    = n_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign ctx_in  = ctx_s[k-1];
		end

		// Bring down two radicand bits and try the next root bit
		assign remsh = {rem_in, n_in[31-2*k -: 2]};
		assign trial = {2'b00, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en[k]) begin
				n_s[k]   <= n_in;
				ctx_s[k] <= ctx_in;
				if (remsh >= trial) begin
					rem_s[k]  <= 18'(remsh - trial);
					root_s[k] <= {root_in[14:0], 1'b1};
				end else begin
					rem_s[k]  <= remsh[17:0];
					root_s[k] <= {root_in[14:0], 1'b0};
				end
			end
		end
	end

	assign out_root = root_s[N-1];
	assign out_ctx  = ctx_s[N-1];

endmodule

// ===== hw/rtl/ccr_div.sv =====
// ----------------------------------------------------------------------------
// ccr_div
// Pipelined restoring divider, two lanes sharing one divisor: rounded
// |dx| * 2^18 / dist and |dy| * 2^18 / dist, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ccr_div import ccr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] in_root,
	input  ctx_t        in_ctx,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] out_qx,
	output logic [14:0] out_qy,
	output logic [15:0] out_dist,
	output ctx_t        out_ctx
);

	localparam int N = DIV_STAGES;

	logic [N-1:0] v_s;
	logic [N:0]   en;

	always_comb begin
		en[N] = out_ready;
		for (int k = N - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[N-1];

	// Numerators with half the divisor added for round-to-nearest
	logic [30:0] numx, numy;
	assign numx = {1'b0, in_ctx.ax, 18'h0} + {15'h0, 1'b0, in_root[15:1]};
	assign numy = {1'b0, in_ctx.ay, 18'h0} + {15'h0, 1'b0, in_root[15:1]};

	logic [30:0] remx_s [N];
	logic [30:0] remy_s [N];
	logic [14:0] qx_s   [N];
	logic [14:0] qy_s   [N];
	logic [15:0] den_s  [N];
	ctx_t        ctx_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [30:0] rx_in, ry_in, sub;
		logic [14:0] qx_in, qy_in;
		logic [15:0] den_in;
		ctx_t        ctx_in;

		if (k == 0) begin : g_first
			assign rx_in  = numx;
			assign ry_in  = numy;
			assign qx_in  = '0;
			assign qy_in  = '0;
			assign den_in = in_root;
			assign ctx_in = in_ctx;
		end else begin : g_next
			assign rx_in  = remx_s[k-1];
			assign ry_in  = remy_s[k-1];
			assign qx_in  = qx_s[k-1];
			assign qy_in  = qy_s[k-1];
			assign den_in = den_s[k-1];
			assign ctx_in = ctx_s[k-1];
		end

		// Divisor aligned to quotient bit N-1-k
		assign sub = 31'({15'h0, den_in} << (N - 1 - k));

		always_ff @(posedge clk) begin
			if (en[k]) begin
				den_s[k] <= den_in;
				ctx_s[k] <= ctx_in;
				if (rx_in >= sub) begin
					remx_s[k] <= rx_in - sub;
					qx_s[k]   <= {qx_in[13:0], 1'b1};
				end else begin
					remx_s[k] <= rx_in;
					qx_s[k]   <= {qx_in[13:0], 1'b0};
				end
				if (ry_in >= sub) begin
					remy_s[k] <= ry_in - sub;
					qy_s[k]   <= {qy_in[13:0], 1'b1};
				end else begin
					remy_s[k] <= ry_in;
					qy_s[k]   <= {qy_in[13:0], 1'b0};
				end
			end
		end
	end

	assign out_qx   = qx_s[N-1];
	assign out_qy   = qy_s[N-1];
	assign out_dist = den_s[N-1];
	assign out_ctx  = ctx_s[N-1];

endmodule

// ===== hw/rtl/ccr_back.sv =====
// ----------------------------------------------------------------------------
// ccr_back
// Form normal and penetration, push the centre out and reflect the
// velocity. Five register stages, the last one is the output register.
// ----------------------------------------------------------------------------
module ccr_back import ccr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [14:0]        in_qx,
	input  logic [14:0]        in_qy,
	input  logic [15:0]        in_dist,
	input  ctx_t               in_ctx,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic [15:0]        penetration,
	output logic signed [15:0] new_x,
	output logic signed [15:0] new_y,
	output logic signed [15:0] new_vel_x,
	output logic signed [15:0] new_vel_y
);

	localparam int N = 5;

	// Shift right by 14, rounding halves away from zero
	function automatic logic signed [33:0] rnd14(input logic signed [33:0] v);
		logic [33:0] mag, q;
		mag = v[33] ? 34'(-v) : 34'(v);
		q   = (mag + 34'd8192) >> 14;
		return v[33] ? -$signed(q) : $signed(q);
	endfunction

	// Shift right by 27, rounding halves away from zero
	function automatic logic signed [50:0] rnd27(input logic signed [50:0] v);
		logic [50:0] mag, q;
		mag = v[50] ? 51'(-v) : 51'(v);
		q   = (mag + 51'd67108864) >> 27;
		return v[50] ? -$signed(q) : $signed(q);
	endfunction

	// Saturate to 16 bit signed
	function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
		if (v > 52'sd32767) return 16'sh7fff;
		if (v < -52'sd32768) return -16'sd32768;
		return v[15:0];
	endfunction

	logic [N-1:0] v_s;
	logic [N:0]   en;

	always_comb begin
		en[N] = out_ready;
		for (int k = N - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[N-1];

	// Stage 1: normal and penetration
	logic signed [16:0] nx_c, ny_c, qxs, qys;
	logic [15:0]        pen_c;
	logic [17:0]        pout;

	always_comb begin
		qxs  = (in_qx > 15'd16384) ? ONE_Q14 : $signed({2'b00, in_qx});
		qys  = (in_qy > 15'd16384) ? ONE_Q14 : $signed({2'b00, in_qy});
		pout = {2'b00, in_ctx.r, 4'h0} - {2'b00, in_dist} + 18'd8;
		nx_c  = '0;
		ny_c  = '0;
		pen_c = '0;
		if (in_ctx.hit && in_ctx.outside) begin
			nx_c  = in_ctx.sx ? -qxs : qxs;
			ny_c  = in_ctx.sy ? -qys : qys;
			pen_c = {2'b00, pout[17:4]};
		end else if (in_ctx.hit) begin
			pen_c = {4'h0, in_ctx.r} + {1'b0, in_ctx.best};
			case (in_ctx.side)
				SIDE_LEFT:   nx_c = -ONE_Q14;
				SIDE_RIGHT:  nx_c = ONE_Q14;
				SIDE_TOP:    ny_c = -ONE_Q14;
				SIDE_BOTTOM: ny_c = ONE_Q14;
				default:     nx_c = -ONE_Q14;
			endcase
		end
	end

	logic signed [16:0] nx_s1, ny_s1;
	logic [15:0]        pen_s1;
	logic signed [15:0] cx_s1, cy_s1, vx_s1, vy_s1;
	logic               hit_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			nx_s1  <= nx_c;
			ny_s1  <= ny_c;
			pen_s1 <= pen_c;
			cx_s1  <= in_ctx.cx;
			cy_s1  <= in_ctx.cy;
			vx_s1  <= in_ctx.vx;
			vy_s1  <= in_ctx.vy;
			hit_s1 <= in_ctx.hit;
		end
	end

	// Stage 2: push-out products and velocity dot terms
	logic signed [33:0] px_s2, py_s2;
	logic signed [32:0] dvx_s2, dvy_s2;
	logic signed [16:0] nx_s2, ny_s2;
	logic [15:0]        pen_s2;
	logic signed [15:0] cx_s2, cy_s2, vx_s2, vy_s2;
	logic               hit_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			px_s2  <= nx_s1 * $signed({1'b0, pen_s1});
			py_s2  <= ny_s1 * $signed({1'b0, pen_s1});
			dvx_s2 <= vx_s1 * nx_s1;
			dvy_s2 <= vy_s1 * ny_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			pen_s2 <= pen_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			hit_s2 <= hit_s1;
		end
	end

	// Stage 3: corrected centre and dot product
	logic signed [33:0] pushx, pushy;
	assign pushx = rnd14(px_s2);
	assign pushy = rnd14(py_s2);

	logic signed [33:0] dot_s3;
	logic signed [16:0] nx_s3, ny_s3;
	logic [15:0]        pen_s3;
	logic signed [15:0] nxo_s3, nyo_s3, vx_s3, vy_s3;
	logic               hit_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dot_s3 <= 34'(dvx_s2) + 34'(dvy_s2);
			nxo_s3 <= sat16(52'(cx_s2) + 52'(pushx));
			nyo_s3 <= sat16(52'(cy_s2) + 52'(pushy));
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			pen_s3 <= pen_s2;
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
			hit_s3 <= hit_s2;
		end
	end

	// Stage 4: reflection products
	logic signed [50:0] rx_s4, ry_s4;
	logic               neg_s4;
	logic signed [16:0] nx_s4, ny_s4;
	logic [15:0]        pen_s4;
	logic signed [15:0] nxo_s4, nyo_s4, vx_s4, vy_s4;
	logic               hit_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			rx_s4  <= dot_s3 * nx_s3;
			ry_s4  <= dot_s3 * ny_s3;
			neg_s4 <= dot_s3[33];
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			pen_s4 <= pen_s3;
			nxo_s4 <= nxo_s3;
			nyo_s4 <= nyo_s3;
			vx_s4  <= vx_s3;
			vy_s4  <= vy_s3;
			hit_s4 <= hit_s3;
		end
	end

	// Stage 5: reflect only when moving into the surface; output register
	logic signed [50:0] cox, coy;
	assign cox = rnd27(rx_s4);
	assign coy = rnd27(ry_s4);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			hit         <= hit_s4;
			normal_x    <= nx_s4[15:0];
			normal_y    <= ny_s4[15:0];
			penetration <= pen_s4;
			new_x       <= nxo_s4;
			new_y       <= nyo_s4;
			new_vel_x   <= neg_s4 ? sat16(52'(vx_s4) - 52'(cox)) : vx_s4;
			new_vel_y   <= neg_s4 ? sat16(52'(vy_s4) - 52'(coy)) : vy_s4;
		end
	end

endmodule
